@@ src/lru_kvc_pkg.sv @@
// Shared types and constants for the LRU key/value cache.
// Used by the controller, the datapath and the top level; depends on nothing.
package lru_kvc_pkg;

   localparam int DEPTH         = 16;
   localparam int IDX_W         = $clog2(DEPTH);
   localparam int COUNT_W       = $clog2(DEPTH + 1);
   localparam int KEY_W         = 31;
   localparam int PAY_W         = 32;
   localparam int CAP_W         = 5;
   localparam int REQ_W         = 2;
   localparam int REQ_DATA_W    = 64;
   localparam int RSP_DATA_W    = 64;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   // request codes
   localparam logic [REQ_W-1:0] REQ_GET    = 2'd0;
   localparam logic [REQ_W-1:0] REQ_PUT    = 2'd1;
   localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_LOOKUP = 3'b010,
      ST_WRITE  = 3'b100
   } state_type;

   typedef struct packed {
      logic load_req;
      logic lookup;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic rsp_stall;
   } dp_status_type;

endpackage

@@ src/lru_kvc_ctrl.sv @@
// Controller state machine of the LRU key/value cache: sequences accept, lookup, write-back.
// Depends on lru_kvc_pkg.
module lru_kvc_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  lru_kvc_pkg::dp_status_type status,
   output lru_kvc_pkg::dp_cmd_type    cmd
);
   import lru_kvc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd.load_req = 1'b0;
      cmd.lookup   = 1'b0;
      cmd.commit   = 1'b0;
      req_tready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_WRITE;
         end
         ST_WRITE: begin
            // hold the write-back until the result register can take the beat
            if (!status.rsp_stall) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ src/lru_kvc_dp.sv @@
// Datapath of the LRU key/value cache: entry store, associative lookup, rank update, result register.
// Depends on lru_kvc_pkg.
module lru_kvc_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  lru_kvc_pkg::dp_cmd_type     cmd,
   output lru_kvc_pkg::dp_status_type  status,
   input  logic [lru_kvc_pkg::REQ_W-1:0] req_type,
   input  logic [lru_kvc_pkg::KEY_W-1:0] req_key,
   input  logic [lru_kvc_pkg::PAY_W-1:0] req_payload,
   input  logic                        cap_we,
   input  logic [lru_kvc_pkg::CAP_W-1:0] cap_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_hit,
   output logic [lru_kvc_pkg::PAY_W-1:0] rsp_payload,
   output logic                        rsp_evicted,
   output logic [lru_kvc_pkg::KEY_W-1:0] rsp_evicted_key
);
   import lru_kvc_pkg::*;

   // request registers
   logic [REQ_W-1:0] op_ff;
   logic [KEY_W-1:0] key_ff;
   logic [PAY_W-1:0] pay_ff;
   logic [CAP_W-1:0] cap_ff;

   // entry store
   logic [DEPTH-1:0]   valid_ff;
   logic [KEY_W-1:0]   ekey_ff  [DEPTH];
   logic [PAY_W-1:0]   epay_ff  [DEPTH];
   logic [IDX_W-1:0]   rank_ff  [DEPTH];
   logic [COUNT_W-1:0] count_ff;

   // lookup results
   logic               hit_ff;
   logic [IDX_W-1:0]   match_idx_ff;
   logic [IDX_W-1:0]   rank_sel_ff;
   logic               evict_ff;
   logic [IDX_W-1:0]   lru_idx_ff;
   logic               free_ok_ff;
   logic [IDX_W-1:0]   free_idx_ff;
   logic [PAY_W-1:0]   rd_pay_ff;
   logic [KEY_W-1:0]   rd_key_ff;

   // result register
   logic               rsp_valid_ff;
   logic               rsp_hit_ff;
   logic [PAY_W-1:0]   rsp_pay_ff;
   logic               rsp_ev_ff;
   logic [KEY_W-1:0]   rsp_evk_ff;

   // lookup logic
   logic [DEPTH-1:0]   match_vec;
   logic [DEPTH-1:0]   lru_vec;
   logic [DEPTH-1:0]   valid_after;
   logic [IDX_W-1:0]   match_idx;
   logic [IDX_W-1:0]   lru_idx;
   logic [IDX_W-1:0]   free_idx;
   logic               free_ok;
   logic               any_hit;
   logic               evict;
   logic [COUNT_W-1:0] eff_cap;
   logic [IDX_W-1:0]   lru_rank;
   logic               known_op;

   assign lru_rank = IDX_W'(count_ff - COUNT_W'(1));
   assign known_op = (op_ff == REQ_GET) || (op_ff == REQ_PUT) || (op_ff == REQ_REMOVE);

   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = COUNT_W'(1);
      end else if (COUNT_W'(cap_ff) > COUNT_W'(DEPTH)) begin
         eff_cap = COUNT_W'(DEPTH);
      end else begin
         eff_cap = COUNT_W'(cap_ff);
      end
   end

   always_comb begin
      match_idx = '0;
      lru_idx   = '0;
      for (int i = 0; i < DEPTH; i++) begin
         match_vec[i] = valid_ff[i] && (ekey_ff[i] == key_ff);
         lru_vec[i]   = valid_ff[i] && (rank_ff[i] == lru_rank);
         if (match_vec[i]) match_idx = match_idx | IDX_W'(i);
         if (lru_vec[i])   lru_idx   = lru_idx | IDX_W'(i);
      end
      any_hit     = known_op && (|match_vec);
      evict       = (op_ff == REQ_PUT) && !any_hit && (count_ff >= eff_cap)
                    && (count_ff != '0);
      valid_after = valid_ff & ~(evict ? lru_vec : '0);
      free_ok     = 1'b0;
      free_idx    = '0;
      // lowest free slot after the eviction
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (!valid_after[i]) begin
            free_ok  = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff  <= req_type;
         key_ff <= req_key;
         pay_ff <= req_payload;
      end
      if (cmd.lookup) begin
         hit_ff       <= any_hit;
         match_idx_ff <= match_idx;
         rank_sel_ff  <= rank_ff[match_idx];
         evict_ff     <= evict;
         lru_idx_ff   <= lru_idx;
         free_ok_ff   <= free_ok;
         free_idx_ff  <= free_idx;
         rd_pay_ff    <= epay_ff[match_idx];
         rd_key_ff    <= ekey_ff[lru_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (cap_we) begin
         cap_ff <= cap_data;
      end
   end

   // write-back of the entry store
   logic               put_miss;
   logic [COUNT_W-1:0] count_in;

   assign put_miss = (op_ff == REQ_PUT) && !hit_ff;

   always_comb begin
      count_in = count_ff;
      if (hit_ff && (op_ff == REQ_REMOVE)) begin
         count_in = count_ff - COUNT_W'(1);
      end else if (put_miss) begin
         count_in = count_ff + COUNT_W'(free_ok_ff) - COUNT_W'(evict_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
         for (int i = 0; i < DEPTH; i++) begin
            if (hit_ff && (op_ff == REQ_REMOVE) && (IDX_W'(i) == match_idx_ff)) begin
               valid_ff[i] <= 1'b0;
            end else if (put_miss) begin
               // the evicted slot may be refilled by the new key
               if (free_ok_ff && (IDX_W'(i) == free_idx_ff)) begin
                  valid_ff[i] <= 1'b1;
               end else if (evict_ff && (IDX_W'(i) == lru_idx_ff)) begin
                  valid_ff[i] <= 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         for (int i = 0; i < DEPTH; i++) begin
            if (hit_ff && ((op_ff == REQ_GET) || (op_ff == REQ_PUT))) begin
               // promote: entries more recent than the target move back one place
               if (IDX_W'(i) == match_idx_ff) begin
                  rank_ff[i] <= '0;
                  if (op_ff == REQ_PUT) epay_ff[i] <= pay_ff;
               end else if (valid_ff[i] && (rank_ff[i] < rank_sel_ff)) begin
                  rank_ff[i] <= rank_ff[i] + IDX_W'(1);
               end
            end else if (hit_ff && (op_ff == REQ_REMOVE)) begin
               if ((IDX_W'(i) != match_idx_ff) && valid_ff[i]
                   && (rank_ff[i] > rank_sel_ff)) begin
                  rank_ff[i] <= rank_ff[i] - IDX_W'(1);
               end
            end else if (put_miss && free_ok_ff) begin
               if (IDX_W'(i) == free_idx_ff) begin
                  ekey_ff[i] <= key_ff;
                  epay_ff[i] <= pay_ff;
                  rank_ff[i] <= '0;
               end else if (valid_ff[i] && !(evict_ff && (IDX_W'(i) == lru_idx_ff))) begin
                  rank_ff[i] <= rank_ff[i] + IDX_W'(1);
               end
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff <= hit_ff;
         rsp_pay_ff <= (hit_ff && (op_ff == REQ_GET)) ? rd_pay_ff : '0;
         rsp_ev_ff  <= evict_ff;
         rsp_evk_ff <= evict_ff ? rd_key_ff : '0;
      end
   end

   assign status.rsp_stall = rsp_valid_ff && !rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_payload      = rsp_pay_ff;
   assign rsp_evicted      = rsp_ev_ff;
   assign rsp_evicted_key  = rsp_evk_ff;

endmodule

@@ src/lru_key_value_cache.sv @@
// LRU key/value cache, 16 fully associative entries. A new request is taken only after the
// last one has passed write-back: the accept state registers the request, the lookup state
// compares the key with all sixteen entries at once and picks the least recent and the first
// free slot, and the write-back state updates payload, valid bits and recency ranks and loads
// the result register. The request side is ready again right after write-back, even while the
// result still waits; write-back itself holds while an earlier result has not been taken. The
// entry store needs no clearing pass after reset. Capacity may be written at any idle time.
// Top level; depends on lru_kvc_pkg, lru_kvc_ctrl and lru_kvc_dp.
module lru_key_value_cache (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // key[30:0], payload_in[62:31], zero[63]
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // payload_out[31:0], evicted_key[62:32], zero[63]
   output logic [1:0]  rsp_tuser,   // hit[0], evicted[1]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data     // capacity[4:0]
);
   import lru_kvc_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   logic               rsp_hit;
   logic               rsp_evicted;
   logic [PAY_W-1:0]   rsp_payload;
   logic [KEY_W-1:0]   rsp_evicted_key;

   assign csr_ready = 1'b1;

   lru_kvc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lru_kvc_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_type        (req_tuser),
      .req_key         (req_tdata[KEY_W-1:0]),
      .req_payload     (req_tdata[KEY_W+PAY_W-1:KEY_W]),
      .cap_we          (csr_valid && csr_ready),
      .cap_data        (csr_data),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_hit         (rsp_hit),
      .rsp_payload     (rsp_payload),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_key (rsp_evicted_key)
   );

   assign rsp_tdata = {1'b0, rsp_evicted_key, rsp_payload};
   assign rsp_tuser = {rsp_evicted, rsp_hit};

endmodule

@@ src/lru_kvc_checker.sv @@
// Port-level checks for the LRU key/value cache, bound to the top level.
// Depends on lru_key_value_cache's port list only.
module lru_kvc_port_checks (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // one request at a time: no accept in the cycle after an accept
   a_req_gap: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted during lookup");

   // an eviction only happens on a put of a new key
   a_ev_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("hit and eviction in one result");

   // fields without their flag read zero
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] || (rsp_tdata[31:0] == 32'd0))
                  && (rsp_tuser[1] || (rsp_tdata[62:32] == 31'd0)))
      else $error("payload or evicted key not zero");

endmodule

bind lru_key_value_cache lru_kvc_port_checks u_lru_kvc_port_checks (.*);
